// ===== hw/rtl/bbu_pkg.sv =====
// bilinear block upscaler: shared types, constants and the reciprocal table
// used by the sequencer, the datapath and the top level; no dependencies
`default_nettype none

package bbu_pkg;

    localparam int MAX_FACTOR = 8;
    localparam int MAX_WIDTH  = 4096;

    localparam int FACTOR_W = 4;
    localparam int WIDTH_W  = 13;
    localparam int PIX_W    = 8;
    localparam int POS_W    = 12;
    localparam int SUB_W    = 3;
    localparam int ADDR_W   = 30;
    localparam int NUM_W    = 14;
    localparam int RECIP_W  = 21;
    localparam int RECIP_SH = 20;
    localparam int MUL_A_W  = 22;
    localparam int MUL_B_W  = 17;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;

    localparam logic CFG_SCALE_FACTOR = 1'b0;
    localparam logic CFG_IMAGE_WIDTH  = 1'b1;

    typedef logic signed [MUL_A_W-1:0] t_opa;
    typedef logic signed [MUL_B_W-1:0] t_opb;
    typedef logic signed [PROD_W-1:0]  t_prod;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ,
        S_RF,
        S_WF,
        S_BASE,
        S_CF,
        S_FTOP,
        S_DTOP,
        S_DV,
        S_RUN
    } t_state;

    typedef struct packed {
        t_state                state;
        logic                  accept;
        logic                  row_last;
        logic                  col_last;
        logic [FACTOR_W-1:0]   f;
        logic [SUB_W-1:0]      sub_col;
        logic [SUB_W-1:0]      sub_row;
    } t_ctrl;

    // ceil(2^20 / f^2), exact floor division for numerators below 2^14
    function automatic logic [RECIP_W-1:0] recip_sq(input logic [FACTOR_W-1:0] f);
        logic [RECIP_W-1:0] r;
        case (f)
            4'd2:    r = 21'd262144;
            4'd3:    r = 21'd116509;
            4'd4:    r = 21'd65536;
            4'd5:    r = 21'd41944;
            4'd6:    r = 21'd29128;
            4'd7:    r = 21'd21400;
            4'd8:    r = 21'd16384;
            default: r = 21'd1048576;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bbu_mul.sv =====
// bilinear block upscaler: shared signed multiplier
// used for address setup, corner weights and the divide by f^2; needs bbu_pkg
`default_nettype none

module bbu_mul (
    input  wire bbu_pkg::t_opa  i_op_a,
    input  wire bbu_pkg::t_opb  i_op_b,
    output bbu_pkg::t_prod      o_prod
);
    import bbu_pkg::*;

    assign o_prod = t_prod'(i_op_a) * t_prod'(i_op_b);

endmodule

`default_nettype wire

// ===== hw/rtl/bbu_ctrl.sv =====
// bilinear block upscaler: sequencer with setup steps and sub-column/sub-row counters
// needs bbu_pkg
`default_nettype none

module bbu_ctrl (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          start,
    input  wire [bbu_pkg::FACTOR_W-1:0]  i_f_eff,
    output logic                         busy,
    output bbu_pkg::t_ctrl               o_ctrl
);
    import bbu_pkg::*;

    t_state                r_state, n_state;
    logic [FACTOR_W-1:0]   r_f;
    logic [SUB_W-1:0]      r_c, n_c;
    logic [SUB_W-1:0]      r_r, n_r;
    logic                  accept;
    logic                  row_last;
    logic                  col_last;

    assign busy     = (r_state != S_IDLE);
    assign accept   = start && !busy;
    assign row_last = (r_r == SUB_W'(r_f - 4'd1));
    assign col_last = (r_c == SUB_W'(r_f - 4'd1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_c     <= '0;
            r_r     <= '0;
            r_f     <= 4'd1;
        end else begin
            r_state <= n_state;
            r_c     <= n_c;
            r_r     <= n_r;
            if (accept) begin
                r_f <= i_f_eff;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_c     = r_c;
        n_r     = r_r;
        case (r_state)
            S_IDLE: begin
                n_c = '0;
                n_r = '0;
                if (accept) begin
                    n_state = S_SQ;
                end
            end
            S_SQ:   n_state = S_RF;
            S_RF:   n_state = S_WF;
            S_WF:   n_state = S_BASE;
            S_BASE: n_state = S_CF;
            S_CF:   n_state = S_FTOP;
            S_FTOP: n_state = S_DTOP;
            S_DTOP: n_state = S_DV;
            S_DV:   n_state = S_RUN;
            S_RUN: begin
                if (row_last) begin
                    n_r = '0;
                    if (col_last) begin
                        n_c     = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_c = r_c + 3'd1;
                    end
                end else begin
                    n_r = r_r + 3'd1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ctrl.state    = r_state;
        o_ctrl.accept   = accept;
        o_ctrl.row_last = row_last;
        o_ctrl.col_last = col_last;
        o_ctrl.f        = r_f;
        o_ctrl.sub_col  = r_c;
        o_ctrl.sub_row  = r_r;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/bbu_dp.sv =====
// bilinear block upscaler: datapath with operand select, accumulators and result registers
// needs bbu_pkg and bbu_mul
`default_nettype none

module bbu_dp (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire bbu_pkg::t_ctrl          i_ctrl,
    input  wire [bbu_pkg::WIDTH_W-1:0]   i_w_eff,
    input  wire [bbu_pkg::PIX_W-1:0]     i_pixel_here,
    input  wire [bbu_pkg::PIX_W-1:0]     i_pixel_right,
    input  wire [bbu_pkg::PIX_W-1:0]     i_pixel_below,
    input  wire [bbu_pkg::PIX_W-1:0]     i_pixel_below_right,
    input  wire [bbu_pkg::POS_W-1:0]     i_block_column,
    input  wire [bbu_pkg::POS_W-1:0]     i_block_row,
    output logic                         o_valid,
    output logic [bbu_pkg::PIX_W-1:0]    o_pixel_value,
    output logic [bbu_pkg::SUB_W-1:0]    o_sub_column,
    output logic [bbu_pkg::SUB_W-1:0]    o_sub_row,
    output logic [bbu_pkg::ADDR_W-1:0]   o_output_address,
    output logic                         o_last_of_block
);
    import bbu_pkg::*;

    // request fields held for the whole block
    logic [PIX_W-1:0]         r_a;
    logic signed [PIX_W:0]    r_ba;
    logic signed [PIX_W:0]    r_da;
    logic signed [PIX_W+1:0]  r_ddv;
    logic [POS_W-1:0]         r_row;
    logic [POS_W-1:0]         r_col;
    logic [WIDTH_W-1:0]       r_w;

    // setup products and accumulators
    logic [6:0]               r_sq;
    logic [15:0]              r_rf;
    logic [15:0]              r_wf;
    logic [14:0]              r_cf;
    logic [ADDR_W-1:0]        r_line;
    logic [ADDR_W-1:0]        r_addr;
    logic [NUM_W-1:0]         r_ftop;
    logic [NUM_W-1:0]         r_num;
    logic signed [11:0]       r_dtop;
    logic signed [11:0]       r_dv;

    t_opa                     op_a;
    t_opb                     op_b;
    t_prod                    prod;
    logic [NUM_W-1:0]         ftop_next;
    logic [ADDR_W-1:0]        line_next;

    bbu_mul u_mul (
        .i_op_a (op_a),
        .i_op_b (op_b),
        .o_prod (prod)
    );

    assign ftop_next = r_ftop + NUM_W'(r_dtop);
    assign line_next = r_line + 30'd1;

    always_comb begin
        op_a = '0;
        op_b = '0;
        case (i_ctrl.state)
            S_SQ: begin
                op_a = t_opa'({1'b0, i_ctrl.f});
                op_b = t_opb'({1'b0, i_ctrl.f});
            end
            S_RF: begin
                op_a = t_opa'({1'b0, r_row});
                op_b = t_opb'({1'b0, i_ctrl.f});
            end
            S_WF: begin
                op_a = t_opa'({1'b0, r_w});
                op_b = t_opb'({1'b0, i_ctrl.f});
            end
            S_BASE: begin
                op_a = t_opa'({1'b0, r_rf});
                op_b = t_opb'({1'b0, r_wf});
            end
            S_CF: begin
                op_a = t_opa'({1'b0, r_col});
                op_b = t_opb'({1'b0, i_ctrl.f});
            end
            S_FTOP: begin
                op_a = t_opa'({1'b0, r_sq});
                op_b = t_opb'({1'b0, r_a});
            end
            S_DTOP: begin
                op_a = t_opa'(r_ba);
                op_b = t_opb'({1'b0, i_ctrl.f});
            end
            S_DV: begin
                op_a = t_opa'(r_da);
                op_b = t_opb'({1'b0, i_ctrl.f});
            end
            S_RUN: begin
                op_a = t_opa'({1'b0, recip_sq(i_ctrl.f)});
                op_b = t_opb'({1'b0, r_num});
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.accept) begin
            r_a   <= i_pixel_here;
            r_ba  <= $signed({1'b0, i_pixel_right}) - $signed({1'b0, i_pixel_here});
            r_da  <= $signed({1'b0, i_pixel_below}) - $signed({1'b0, i_pixel_here});
            r_ddv <= $signed({2'b0, i_pixel_below_right}) - $signed({2'b0, i_pixel_right})
                   - $signed({2'b0, i_pixel_below}) + $signed({2'b0, i_pixel_here});
            r_row <= i_block_row;
            r_col <= i_block_column;
            r_w   <= i_w_eff;
        end
        case (i_ctrl.state)
            S_SQ:   r_sq   <= prod[6:0];
            S_RF:   r_rf   <= prod[15:0];
            S_WF:   r_wf   <= prod[15:0];
            S_BASE: r_line <= prod[ADDR_W-1:0];
            S_CF:   r_cf   <= prod[14:0];
            S_FTOP: begin
                r_ftop <= prod[NUM_W-1:0];
                r_line <= r_line + ADDR_W'(r_cf);
            end
            S_DTOP: r_dtop <= prod[11:0];
            S_DV: begin
                r_dv   <= prod[11:0];
                r_num  <= r_ftop;
                r_addr <= r_line;
            end
            S_RUN: begin
                if (i_ctrl.row_last) begin
                    r_ftop <= ftop_next;
                    r_num  <= ftop_next;
                    r_dv   <= r_dv + 12'(r_ddv);
                    r_line <= line_next;
                    r_addr <= line_next;
                end else begin
                    r_num  <= r_num + NUM_W'(r_dv);
                    r_addr <= r_addr + ADDR_W'(r_wf);
                end
            end
            default: begin
            end
        endcase
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= (i_ctrl.state == S_RUN);
        end
    end

    always_ff @(posedge i_clk) begin
        o_pixel_value    <= prod[RECIP_SH+PIX_W-1:RECIP_SH];
        o_sub_column     <= i_ctrl.sub_col;
        o_sub_row        <= i_ctrl.sub_row;
        o_output_address <= r_addr;
        o_last_of_block  <= i_ctrl.row_last && i_ctrl.col_last;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/bilinear_block_upscaler_top.sv =====
// once start is taken, 8 setup steps run on the shared multiplier, then the block's
// pixels leave through the result registers, one pixel per cycle; F*F pixels per
// block, last one flagged; a new request is taken only while idle
// reset: synchronous active low, returns to idle, factor 1 and width 640
// the receiver cannot stall: every pixel is shown for exactly one cycle on o_valid
`default_nettype none

module bilinear_block_upscaler_top (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          start,
    output logic                         busy,
    input  wire                          i_cfg_we,
    input  wire                          i_cfg_index,
    input  wire [bbu_pkg::WIDTH_W-1:0]   i_cfg_data,
    input  wire [bbu_pkg::PIX_W-1:0]     i_pixel_here,
    input  wire [bbu_pkg::PIX_W-1:0]     i_pixel_right,
    input  wire [bbu_pkg::PIX_W-1:0]     i_pixel_below,
    input  wire [bbu_pkg::PIX_W-1:0]     i_pixel_below_right,
    input  wire [bbu_pkg::POS_W-1:0]     i_block_column,
    input  wire [bbu_pkg::POS_W-1:0]     i_block_row,
    output logic                         o_valid,
    output logic [bbu_pkg::PIX_W-1:0]    o_pixel_value,
    output logic [bbu_pkg::SUB_W-1:0]    o_sub_column,
    output logic [bbu_pkg::SUB_W-1:0]    o_sub_row,
    output logic [bbu_pkg::ADDR_W-1:0]   o_output_address,
    output logic                         o_last_of_block
);
    import bbu_pkg::*;

    logic [FACTOR_W-1:0]  r_scale_factor;
    logic [WIDTH_W-1:0]   r_image_width;
    logic [FACTOR_W-1:0]  f_eff;
    logic [WIDTH_W-1:0]   w_eff;
    t_ctrl                ctrl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale_factor <= 4'd1;
            r_image_width  <= 13'd640;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SCALE_FACTOR: r_scale_factor <= i_cfg_data[FACTOR_W-1:0];
                CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // clamp registers to the supported range
    always_comb begin
        f_eff = r_scale_factor;
        if (r_scale_factor == '0) begin
            f_eff = 4'd1;
        end else if (r_scale_factor > FACTOR_W'(MAX_FACTOR)) begin
            f_eff = FACTOR_W'(MAX_FACTOR);
        end
        w_eff = r_image_width;
        if (r_image_width == '0) begin
            w_eff = 13'd1;
        end else if (r_image_width > WIDTH_W'(MAX_WIDTH)) begin
            w_eff = WIDTH_W'(MAX_WIDTH);
        end
    end

    bbu_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_f_eff (f_eff),
        .busy    (busy),
        .o_ctrl  (ctrl)
    );

    bbu_dp u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_ctrl              (ctrl),
        .i_w_eff             (w_eff),
        .i_pixel_here        (i_pixel_here),
        .i_pixel_right       (i_pixel_right),
        .i_pixel_below       (i_pixel_below),
        .i_pixel_below_right (i_pixel_below_right),
        .i_block_column      (i_block_column),
        .i_block_row         (i_block_row),
        .o_valid             (o_valid),
        .o_pixel_value       (o_pixel_value),
        .o_sub_column        (o_sub_column),
        .o_sub_row           (o_sub_row),
        .o_output_address    (o_output_address),
        .o_last_of_block     (o_last_of_block)
    );

    // block ends exactly with its flagged last pixel
    a_end_with_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> (o_valid && o_last_of_block))
        else $error("block ended without last pixel");

    // pixels of one block come without gaps
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last_of_block) |=> o_valid)
        else $error("gap inside block");

    // a taken request makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request taken but not busy");

    // results only come from work started earlier
    a_valid_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result without work");

endmodule

`default_nettype wire
